@@ src/nttpm_pkg.sv @@
// Shared constants, codes and types of the NTT polynomial multiplier.
package nttpm_pkg;

  localparam int CW     = 30;
  localparam int LENW   = 10;
  localparam int IDXW   = 10;
  localparam int CFG_IW = 8;

  localparam logic [CW-1:0] MOD_P    = 30'd998244353;
  localparam logic [CW-1:0] GEN      = 30'd3;
  localparam logic [CW-1:0] EXP_BASE = 30'd998244352;

  localparam logic [CFG_IW-1:0] REG_LEN_A = 8'd0;
  localparam logic [CFG_IW-1:0] REG_LEN_B = 8'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_ROUT, S_START, S_ZERO,
    S_POW_INIT, S_POW_SQ, S_POW_SQ_W, S_POW_G, S_POW_G_W,
    S_TW_INIT, S_TW_GO, S_TW_W,
    S_PM_RD_I, S_PM_RD_R, S_PM_WR_I, S_PM_WR_R,
    S_BF_RD_HI, S_BF_RD_LO, S_BF_W, S_BF_WR_HI, S_BF_WR_LO,
    S_PT_RD, S_PT_GO, S_PT_W, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    WR_ZERO, WR_LOAD, WR_ONE, WR_Q, WR_U, WR_SUM, WR_DIFF, WR_MUL
  } wsrc_t;

  typedef enum logic [2:0] {
    MOP_SQ, MOP_G, MOP_TW, MOP_BF, MOP_PW, MOP_SC
  } mop_t;

  typedef struct packed {
    logic  we_a;
    logic  we_b;
    logic  we_t;
    wsrc_t wsrc;
    mop_t  mop;
    logic  mul_start;
    logic  cap_u;
    logic  ld_acc_one;
    logic  ld_acc;
    logic  ld_cur_one;
    logic  ld_cur;
    logic  ld_w;
    logic  res_zero;
  } cmd_t;

endpackage

@@ src/ntt_polynomial_multiply_unit.sv @@
// Top level of the NTT polynomial multiplier modulo 998244353.
// Load beat: one per cycle, busy stays low; a read beat holds busy one cycle and strobes done
//   in the next cycle, and no new read beat is taken while done is strobed.
// A last_load beat starts a multiply run on a transform of size n: each multiply, also the one
//   in each butterfly, is a step of the bit-serial modular multiplier.
// Sync active-high reset clears the controller, not the stores; results cannot stall.
module ntt_polynomial_multiply_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [nttpm_pkg::CW-1:0]     coef_a,
  input  logic [nttpm_pkg::CW-1:0]     coef_b,
  input  logic                         last_load,
  output logic                         done,
  output logic [nttpm_pkg::CW-1:0]     product_coef,
  output logic [nttpm_pkg::IDXW-1:0]   coef_index,
  output logic                         final_coef,
  output logic                         read_error,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nttpm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nttpm_pkg::LENW-1:0]   cfg_data
);
  import nttpm_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS + 1) - 1;
  localparam int LGW = $clog2(AW + 1);

  cmd_t           cmd;
  logic [AW-1:0]  rd_addr, t_addr, wr_addr;
  logic [LGW-1:0] lg;
  logic           mul_done;

  nttpm_ctrl #(.AW(AW), .LGW(LGW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .last_load  (last_load),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mul_done   (mul_done),
    .cfg_ready  (cfg_ready),
    .busy       (busy),
    .done       (done),
    .coef_index (coef_index),
    .final_coef (final_coef),
    .read_error (read_error),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .t_addr     (t_addr),
    .wr_addr    (wr_addr),
    .lg         (lg)
  );

  nttpm_datapath #(.AW(AW), .LGW(LGW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .t_addr       (t_addr),
    .wr_addr      (wr_addr),
    .lg           (lg),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .mul_done     (mul_done),
    .product_coef (product_coef)
  );

endmodule

@@ src/nttpm_mulmod.sv @@
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module nttpm_mulmod (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [nttpm_pkg::CW-1:0] x,
  input  logic [nttpm_pkg::CW-1:0] y,
  output logic                   done,
  output logic [nttpm_pkg::CW-1:0] result
);
  import nttpm_pkg::*;

  localparam logic [CW+1:0] P1 = (CW+2)'(MOD_P);
  localparam logic [CW+1:0] P2 = (CW+2)'(MOD_P) << 1;

  logic [CW-1:0] xr, yr, acc;
  logic [4:0]    cnt;
  logic          run;
  logic [CW+1:0] s;
  logic [CW+1:0] s_red;

  always_comb begin
    s = {1'b0, acc, 1'b0} + (yr[cnt] ? {2'b00, xr} : '0);
    if (s >= P2) s_red = s - P2;
    else if (s >= P1) s_red = s - P1;
    else s_red = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= y;
      acc <= '0;
      cnt <= 5'(CW - 1);
    end else if (run) begin
      acc <= s_red[CW-1:0];
      cnt <= cnt - 5'd1;
    end
  end

  assign result = acc;

endmodule

@@ src/nttpm_datapath.sv @@
// Coefficient and twiddle stores, two multiplier lanes and butterfly arithmetic.
module nttpm_datapath #(
  parameter int AW  = 10,
  parameter int LGW = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nttpm_pkg::cmd_t          cmd,
  input  logic [AW-1:0]            rd_addr,
  input  logic [AW-1:0]            t_addr,
  input  logic [AW-1:0]            wr_addr,
  input  logic [LGW-1:0]           lg,
  input  logic [nttpm_pkg::CW-1:0] coef_a,
  input  logic [nttpm_pkg::CW-1:0] coef_b,
  output logic                     mul_done,
  output logic [nttpm_pkg::CW-1:0] product_coef
);
  import nttpm_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [CW-1:0] mem_a [DEPTH];
  logic [CW-1:0] mem_b [DEPTH];
  logic [CW-1:0] mem_t [DEPTH];
  logic [CW-1:0] q_a, q_b, q_t;
  logic [CW-1:0] acc, cur, w_root, ua, ub;
  logic [CW-1:0] ninv;
  logic [CW-1:0] xa, ya;
  logic [CW-1:0] res_a, res_b;
  logic [CW-1:0] da, db, dt;

  function automatic logic [CW-1:0] red(input logic [CW-1:0] v);
    red = (v >= MOD_P) ? v - MOD_P : v;
  endfunction

  function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] u, input logic [CW-1:0] t);
    logic [CW:0] s;
    s = {1'b0, u} + {1'b0, t};
    if (s >= {1'b0, MOD_P}) s = s - {1'b0, MOD_P};
    add_mod = s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] u, input logic [CW-1:0] t);
    sub_mod = (u >= t) ? u - t : u + (MOD_P - t);
  endfunction

  assign ninv = MOD_P - (EXP_BASE >> lg);

  always_comb begin
    case (cmd.mop)
      MOP_SQ:  begin xa = acc; ya = acc;    end
      MOP_G:   begin xa = acc; ya = GEN;    end
      MOP_TW:  begin xa = cur; ya = w_root; end
      MOP_BF:  begin xa = q_t; ya = q_a;    end
      MOP_PW:  begin xa = q_a; ya = q_b;    end
      MOP_SC:  begin xa = q_a; ya = ninv;   end
      default: begin xa = acc; ya = acc;    end
    endcase
  end

  nttpm_mulmod u_mul_a (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .x      (xa),
    .y      (ya),
    .done   (mul_done),
    .result (res_a)
  );

  nttpm_mulmod u_mul_b (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .x      (q_t),
    .y      (q_b),
    .done   (),
    .result (res_b)
  );

  always_comb begin
    case (cmd.wsrc)
      WR_LOAD: begin da = red(coef_a);       db = red(coef_b);       end
      WR_Q:    begin da = q_a;               db = q_b;               end
      WR_U:    begin da = ua;                db = ub;                end
      WR_SUM:  begin da = add_mod(ua, res_a); db = add_mod(ub, res_b); end
      WR_DIFF: begin da = sub_mod(ua, res_a); db = sub_mod(ub, res_b); end
      WR_MUL:  begin da = res_a;             db = res_b;             end
      default: begin da = '0;                db = '0;                end
    endcase
    dt = (cmd.wsrc == WR_ONE) ? CW'(1) : res_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.we_a) mem_a[wr_addr] <= da;
    if (cmd.we_b) mem_b[wr_addr] <= db;
    if (cmd.we_t) mem_t[wr_addr] <= dt;
    q_a <= mem_a[rd_addr];
    q_b <= mem_b[rd_addr];
    q_t <= mem_t[t_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_acc_one) acc <= CW'(1);
    else if (cmd.ld_acc) acc <= res_a;
    if (cmd.ld_cur_one) cur <= CW'(1);
    else if (cmd.ld_cur) cur <= res_a;
    if (cmd.ld_w) w_root <= acc;
    if (cmd.cap_u) begin
      ua <= q_a;
      ub <= q_b;
    end
  end

  assign product_coef = cmd.res_zero ? '0 : q_a;

endmodule

@@ src/nttpm_ctrl.sv @@
// Sequencer: item handshake, configuration, and the steps of a multiply run.
module nttpm_ctrl #(
  parameter int AW  = 10,
  parameter int LGW = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         func,
  input  logic                         last_load,
  input  logic                         cfg_valid,
  input  logic [nttpm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nttpm_pkg::LENW-1:0]   cfg_data,
  input  logic                         mul_done,
  output logic                         cfg_ready,
  output logic                         busy,
  output logic                         done,
  output logic [nttpm_pkg::IDXW-1:0]   coef_index,
  output logic                         final_coef,
  output logic                         read_error,
  output nttpm_pkg::cmd_t              cmd,
  output logic [AW-1:0]                rd_addr,
  output logic [AW-1:0]                t_addr,
  output logic [AW-1:0]                wr_addr,
  output logic [LGW-1:0]               lg
);
  import nttpm_pkg::*;

  localparam int HALF = 2 ** (AW - 1);

  state_t state, state_next;

  logic [LENW-1:0] len_a, len_b;
  logic [AW-1:0]   cnt, cnt_next, ptr, ptr_next, plen, plen_next, idx, idx_next;
  logic            ready, ready_next, err, err_next, fin, fin_next, inv, inv_next;
  logic [LGW-1:0]  lg_next, s, s_next;
  logic [AW:0]     i, i_next, base, base_next, j, j_next;
  logic [4:0]      bitc, bitc_next;

  logic [AW-1:0]   la, lb, rev_i, r_i;
  logic [AW:0]     sum, n, mid, lo, hi, k, tidx;
  logic [LGW-1:0]  lg_calc;
  logic [CW-1:0]   expo;
  logic            i_last;

  always_comb begin
    if (len_a == '0) la = AW'(1);
    else if (32'(len_a) > 32'(HALF)) la = AW'(HALF);
    else la = AW'(len_a);
    if (len_b == '0) lb = AW'(1);
    else if (32'(len_b) > 32'(HALF)) lb = AW'(HALF);
    else lb = AW'(len_b);
  end

  assign sum = (AW+1)'(la) + (AW+1)'(lb);

  // least power of two covering la + lb, the clamped len_a and len_b
  always_comb begin
    lg_calc = LGW'(AW);
    for (int m = AW; m >= 0; m--) begin
      if ({1'b0, sum} <= ((AW+2)'(1) << m)) lg_calc = LGW'(m);
    end
  end

  assign n      = (AW+1)'(1) << lg;
  assign mid    = (AW+1)'(1) << (s - LGW'(1));
  assign lo     = base + j;
  assign hi     = lo + mid;
  assign k      = j << (lg - s);
  assign tidx   = inv ? ((n - k) & (n - (AW+1)'(1))) : k;
  assign expo   = EXP_BASE >> lg;
  assign i_last = (i == n - (AW+1)'(1));

  always_comb begin
    for (int m = 0; m < AW; m++) rev_i[m] = i[AW-1-m];
    r_i = rev_i >> (LGW'(AW) - lg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len_a <= LENW'(1);
      len_b <= LENW'(1);
      cnt   <= '0;
      ptr   <= '0;
      plen  <= '0;
      ready <= 1'b0;
      err   <= 1'b0;
      fin   <= 1'b0;
      idx   <= '0;
      inv   <= 1'b0;
      lg    <= LGW'(1);
      s     <= LGW'(1);
      i     <= '0;
      base  <= '0;
      j     <= '0;
      bitc  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LEN_A) len_a <= cfg_data;
        else if (cfg_index == REG_LEN_B) len_b <= cfg_data;
      end
      cnt   <= cnt_next;
      ptr   <= ptr_next;
      plen  <= plen_next;
      ready <= ready_next;
      err   <= err_next;
      fin   <= fin_next;
      idx   <= idx_next;
      inv   <= inv_next;
      lg    <= lg_next;
      s     <= s_next;
      i     <= i_next;
      base  <= base_next;
      j     <= j_next;
      bitc  <= bitc_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ptr_next     = ptr;
    plen_next    = plen;
    ready_next   = ready;
    err_next     = err;
    fin_next     = fin;
    idx_next     = idx;
    inv_next     = inv;
    lg_next      = lg;
    s_next       = s;
    i_next       = i;
    base_next    = base;
    j_next       = j;
    bitc_next    = bitc;
    cmd          = '0;
    cmd.wsrc     = WR_ZERO;
    cmd.mop      = MOP_SQ;
    cmd.res_zero = err;
    rd_addr      = ptr;
    t_addr       = tidx[AW-1:0];
    wr_addr      = i[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (!func) begin
            ready_next = 1'b0;
            if (32'(cnt) < 32'(HALF)) begin
              cmd.we_a = 1'b1;
              cmd.we_b = 1'b1;
              cmd.wsrc = WR_LOAD;
              wr_addr  = cnt;
              cnt_next = cnt + AW'(1);
            end
            if (last_load) state_next = S_START;
          end else begin
            if (!ready || ptr >= plen) begin
              err_next = 1'b1;
              idx_next = '0;
              fin_next = 1'b0;
            end else begin
              err_next = 1'b0;
              idx_next = ptr;
              fin_next = (ptr + AW'(1) == plen);
              ptr_next = ptr + AW'(1);
            end
            state_next = S_ROUT;
          end
        end
      end
      S_ROUT: state_next = S_IDLE;
      S_START: begin
        lg_next    = lg_calc;
        i_next     = '0;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        // clear entries past each operand's length or past the loads
        cmd.we_a = (i >= (AW+1)'(cnt)) || (i >= (AW+1)'(la));
        cmd.we_b = (i >= (AW+1)'(cnt)) || (i >= (AW+1)'(lb));
        i_next   = i + (AW+1)'(1);
        if (i_last) state_next = S_POW_INIT;
      end
      S_POW_INIT: begin
        cmd.ld_acc_one = 1'b1;
        bitc_next      = 5'(CW - 1);
        state_next     = S_POW_SQ;
      end
      S_POW_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = MOP_SQ;
        state_next    = S_POW_SQ_W;
      end
      S_POW_SQ_W: begin
        if (mul_done) begin
          cmd.ld_acc = 1'b1;
          if (expo[bitc]) state_next = S_POW_G;
          else if (bitc == '0) state_next = S_TW_INIT;
          else begin
            bitc_next  = bitc - 5'd1;
            state_next = S_POW_SQ;
          end
        end
      end
      S_POW_G: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = MOP_G;
        state_next    = S_POW_G_W;
      end
      S_POW_G_W: begin
        if (mul_done) begin
          cmd.ld_acc = 1'b1;
          if (bitc == '0) state_next = S_TW_INIT;
          else begin
            bitc_next  = bitc - 5'd1;
            state_next = S_POW_SQ;
          end
        end
      end
      S_TW_INIT: begin
        cmd.ld_w       = 1'b1;
        cmd.ld_cur_one = 1'b1;
        cmd.we_t       = 1'b1;
        cmd.wsrc       = WR_ONE;
        wr_addr        = '0;
        i_next         = (AW+1)'(1);
        state_next     = S_TW_GO;
      end
      S_TW_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = MOP_TW;
        state_next    = S_TW_W;
      end
      S_TW_W: begin
        if (mul_done) begin
          cmd.we_t   = 1'b1;
          cmd.wsrc   = WR_MUL;
          cmd.ld_cur = 1'b1;
          if (i_last) begin
            i_next     = '0;
            inv_next   = 1'b0;
            state_next = S_PM_RD_I;
          end else begin
            i_next     = i + (AW+1)'(1);
            state_next = S_TW_GO;
          end
        end
      end
      S_PM_RD_I: begin
        rd_addr = i[AW-1:0];
        if (i[AW-1:0] < r_i) state_next = S_PM_RD_R;
        else if (i_last) begin
          s_next     = LGW'(1);
          base_next  = '0;
          j_next     = '0;
          state_next = S_BF_RD_HI;
        end else i_next = i + (AW+1)'(1);
      end
      S_PM_RD_R: begin
        rd_addr    = r_i;
        cmd.cap_u  = 1'b1;
        state_next = S_PM_WR_I;
      end
      S_PM_WR_I: begin
        cmd.we_a   = 1'b1;
        cmd.we_b   = !inv;
        cmd.wsrc   = WR_Q;
        state_next = S_PM_WR_R;
      end
      S_PM_WR_R: begin
        cmd.we_a = 1'b1;
        cmd.we_b = !inv;
        cmd.wsrc = WR_U;
        wr_addr  = r_i;
        if (i_last) begin
          s_next     = LGW'(1);
          base_next  = '0;
          j_next     = '0;
          state_next = S_BF_RD_HI;
        end else begin
          i_next     = i + (AW+1)'(1);
          state_next = S_PM_RD_I;
        end
      end
      S_BF_RD_HI: begin
        rd_addr    = hi[AW-1:0];
        state_next = S_BF_RD_LO;
      end
      S_BF_RD_LO: begin
        rd_addr       = lo[AW-1:0];
        cmd.mul_start = 1'b1;
        cmd.mop       = MOP_BF;
        state_next    = S_BF_W;
      end
      S_BF_W: begin
        rd_addr   = lo[AW-1:0];
        cmd.cap_u = 1'b1;
        if (mul_done) state_next = S_BF_WR_HI;
      end
      S_BF_WR_HI: begin
        cmd.we_a   = 1'b1;
        cmd.we_b   = !inv;
        cmd.wsrc   = WR_DIFF;
        wr_addr    = hi[AW-1:0];
        state_next = S_BF_WR_LO;
      end
      S_BF_WR_LO: begin
        cmd.we_a   = 1'b1;
        cmd.we_b   = !inv;
        cmd.wsrc   = WR_SUM;
        wr_addr    = lo[AW-1:0];
        state_next = S_BF_RD_HI;
        if (j + (AW+1)'(1) < mid) j_next = j + (AW+1)'(1);
        else begin
          j_next = '0;
          if (base + (mid << 1) < n) base_next = base + (mid << 1);
          else begin
            base_next = '0;
            if (s == lg) begin
              i_next     = '0;
              state_next = S_PT_RD;
            end else s_next = s + LGW'(1);
          end
        end
      end
      S_PT_RD: begin
        rd_addr    = i[AW-1:0];
        state_next = S_PT_GO;
      end
      S_PT_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = inv ? MOP_SC : MOP_PW;
        state_next    = S_PT_W;
      end
      S_PT_W: begin
        if (mul_done) begin
          cmd.we_a = 1'b1;
          cmd.wsrc = WR_MUL;
          if (i_last) begin
            i_next = '0;
            if (inv) state_next = S_FIN;
            else begin
              inv_next   = 1'b1;
              state_next = S_PM_RD_I;
            end
          end else begin
            i_next     = i + (AW+1)'(1);
            state_next = S_PT_RD;
          end
        end
      end
      S_FIN: begin
        ready_next = 1'b1;
        plen_next  = AW'(sum - (AW+1)'(1));
        ptr_next   = '0;
        cnt_next   = '0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign done       = (state == S_ROUT);
  assign coef_index = IDXW'(idx);
  assign final_coef = fin;
  assign read_error = err;

endmodule

@@ src/nttpm_checker.sv @@
// Port-level checks of the NTT polynomial multiplier, bound to the top level.
module nttpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         func,
  input logic [nttpm_pkg::CW-1:0]     coef_a,
  input logic [nttpm_pkg::CW-1:0]     coef_b,
  input logic                         last_load,
  input logic                         done,
  input logic [nttpm_pkg::CW-1:0]     product_coef,
  input logic [nttpm_pkg::IDXW-1:0]   coef_index,
  input logic                         final_coef,
  input logic                         read_error,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [nttpm_pkg::CFG_IW-1:0] cfg_index,
  input logic [nttpm_pkg::LENW-1:0]   cfg_data
);

  // every read beat gives exactly one result in the next cycle
  a_read_strobe: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func) |=> done)
    else $error("read beat without result");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && func))
    else $error("result without read beat");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && read_error) |-> (product_coef == '0 && coef_index == '0 && !final_coef))
    else $error("error result carries data");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func && !last_load) |=> !busy)
    else $error("plain load held the block busy");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func && last_load) |=> (busy && !done))
    else $error("final load did not start a run");

endmodule

bind ntt_polynomial_multiply_unit nttpm_checker u_nttpm_checker (.*);
